[hw/rtl/tidb_pkg.sv]
// package: shared constants, types and command codes of the tomasulo unit
package tidb_pkg;

   localparam int NUM_REGS_DEF     = 8;
   localparam int ADD_STATIONS_DEF = 3;
   localparam int MUL_STATIONS_DEF = 2;
   localparam int QUEUE_DEPTH_DEF  = 16;
   localparam int DATA_WIDTH_DEF   = 32;

   localparam logic [5:0] ADD_LAT_RESET = 6'd2;
   localparam logic [5:0] MUL_LAT_RESET = 6'd10;
   localparam logic [5:0] DIV_LAT_RESET = 6'd40;

   typedef enum logic [1:0] {
      CMD_PRELOAD = 2'd0,
      CMD_ENQUEUE = 2'd1,
      CMD_TICK    = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   localparam logic [1:0] REG_ADD_LAT = 2'd0;
   localparam logic [1:0] REG_MUL_LAT = 2'd1;
   localparam logic [1:0] REG_DIV_LAT = 2'd2;

   // request to the shared arithmetic unit
   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } alu_req_type;

   // status back from the shared arithmetic unit
   typedef struct packed {
      logic done;
      logic dz;
   } alu_rsp_type;

endpackage

[hw/rtl/tidb_if.sv]
// interfaces: request and response channels
interface tidb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [2:0] reg_index;
   logic signed [31:0] reg_value;
   logic [1:0] opcode;
   logic [2:0] dest_reg;
   logic [2:0] src1_reg;
   logic [2:0] src2_reg;
   modport source (output valid, command, reg_index, reg_value, opcode, dest_reg,
                   src1_reg, src2_reg, input ready);
   modport sink (input valid, command, reg_index, reg_value, opcode, dest_reg,
                 src1_reg, src2_reg, output ready);
endinterface

interface tidb_rsp_if;
   logic       valid;
   logic       ready;
   logic       broadcast_valid;
   logic [2:0] broadcast_tag;
   logic [2:0] broadcast_reg;
   logic signed [31:0] broadcast_value;
   logic       divide_by_zero;
   logic       issued;
   logic       issue_stalled;
   logic       queue_full;
   logic [4:0] queue_count;
   modport source (output valid, broadcast_valid, broadcast_tag, broadcast_reg,
                   broadcast_value, divide_by_zero, issued, issue_stalled, queue_full,
                   queue_count, input ready);
   modport sink (input valid, broadcast_valid, broadcast_tag, broadcast_reg,
                 broadcast_value, divide_by_zero, issued, issue_stalled, queue_full,
                 queue_count, output ready);
endinterface

[hw/rtl/tidb_alu.sv]
// shared arithmetic unit: add, sub, shift-add multiply, restoring divide
module tidb_alu #(
   parameter int DATA_WIDTH = tidb_pkg::DATA_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tidb_pkg::alu_req_type      req,
   input  logic [DATA_WIDTH-1:0]      a,
   input  logic [DATA_WIDTH-1:0]      b,
   output tidb_pkg::alu_rsp_type      rsp,
   output logic [DATA_WIDTH-1:0]      result
);
   localparam int CW = $clog2(DATA_WIDTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_type;

   state_type             state_ff;
   logic [CW-1:0]         cnt_ff;
   logic [DATA_WIDTH-1:0] acc_ff, opa_ff, opb_ff, rem_ff;
   logic                  neg_ff, dz_ff;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH-1:0] rem_sh;
   logic [DATA_WIDTH-1:0] abs_a, abs_b;

   assign abs_a  = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
   assign abs_b  = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
   assign rem_sh = {rem_ff[DATA_WIDTH-2:0], opa_ff[DATA_WIDTH-1]};
   assign trial  = {1'b0, rem_sh} - {1'b0, opb_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req.start) begin
                  dz_ff  <= 1'b0;
                  cnt_ff <= CW'(DATA_WIDTH);
                  unique case (req.op)
                     tidb_pkg::OP_ADD: begin
                        acc_ff   <= a + b;
                        state_ff <= S_DONE;
                     end
                     tidb_pkg::OP_SUB: begin
                        acc_ff   <= a - b;
                        state_ff <= S_DONE;
                     end
                     tidb_pkg::OP_MUL: begin
                        acc_ff   <= '0;
                        opa_ff   <= a;
                        opb_ff   <= b;
                        state_ff <= S_MUL;
                     end
                     default: begin
                        if (b == '0) begin
                           acc_ff   <= '0;
                           dz_ff    <= 1'b1;
                           state_ff <= S_DONE;
                        end else begin
                           opa_ff   <= abs_a;
                           opb_ff   <= abs_b;
                           rem_ff   <= '0;
                           acc_ff   <= '0;
                           neg_ff   <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
                           state_ff <= S_DIV;
                        end
                     end
                  endcase
               end
            end
            S_MUL: begin
               // one bit of the multiplier per cycle, low bit first
               if (opb_ff[0]) acc_ff <= acc_ff + opa_ff;
               opa_ff <= {opa_ff[DATA_WIDTH-2:0], 1'b0};
               opb_ff <= {1'b0, opb_ff[DATA_WIDTH-1:1]};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) state_ff <= S_DONE;
            end
            S_DIV: begin
               // one quotient bit per cycle, high bit first
               opa_ff <= {opa_ff[DATA_WIDTH-2:0], 1'b0};
               if (!trial[DATA_WIDTH]) begin
                  rem_ff <= trial[DATA_WIDTH-1:0];
                  acc_ff <= {acc_ff[DATA_WIDTH-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  acc_ff <= {acc_ff[DATA_WIDTH-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) state_ff <= S_DONE;
            end
            default: begin
               if (neg_ff && !dz_ff) acc_ff <= ~acc_ff + 1'b1;
               neg_ff   <= 1'b0;
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp.done = (state_ff == S_DONE);
   assign rsp.dz   = dz_ff;
   assign result   = (neg_ff && !dz_ff) ? (~acc_ff + 1'b1) : acc_ff;
endmodule

[hw/rtl/tomasulo_issue_dispatch_broadcast_unit.sv]
// top level: tomasulo issue, dispatch and broadcast core with csr port
//
//   channel   dir   handshake      contents
//   req       in    valid/ready    command, register preload, instruction
//   rsp       out   valid/ready    broadcast bus, issue status, queue count
//   csr       in    apb            add, mul and div latency registers
//
// preload, enqueue and unknown words go straight to the response state; a tick word
// passes through dispatch, issue and broadcast, and when the bus carries a result it
// also waits for the shared alu, which computes a mul/div broadcast result bit by bit.
// a stalled rsp.ready holds the response word until it is taken.
// reset is synchronous; it clears queue pointers, rat, stations and units.
// req.ready is low from acceptance until the response word is taken.
module tomasulo_issue_dispatch_broadcast_unit #(
   parameter int NUM_REGS     = tidb_pkg::NUM_REGS_DEF,
   parameter int ADD_STATIONS = tidb_pkg::ADD_STATIONS_DEF,
   parameter int MUL_STATIONS = tidb_pkg::MUL_STATIONS_DEF,
   parameter int QUEUE_DEPTH  = tidb_pkg::QUEUE_DEPTH_DEF,
   parameter int DATA_WIDTH   = tidb_pkg::DATA_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tidb_req_if.sink    req,
   tidb_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int NS  = ADD_STATIONS + MUL_STATIONS;
   localparam int TW  = $clog2(NS + 1);
   localparam int RW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int AW  = (ADD_STATIONS > 1) ? $clog2(ADD_STATIONS) : 1;
   localparam int MW  = (MUL_STATIONS > 1) ? $clog2(MUL_STATIONS) : 1;
   localparam int SW  = (NS > 1) ? $clog2(NS) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_DISP, S_ISSUE, S_BCAST, S_WAIT, S_FIN, S_OUT
   } state_type;

   // latency registers
   logic [5:0] add_lat_ff, mul_lat_ff, div_lat_ff;
   logic       csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         add_lat_ff <= tidb_pkg::ADD_LAT_RESET;
         mul_lat_ff <= tidb_pkg::MUL_LAT_RESET;
         div_lat_ff <= tidb_pkg::DIV_LAT_RESET;
      end else if (csr_wr && csr_paddr[1:0] == 2'b00) begin
         unique case (csr_paddr[3:2])
            tidb_pkg::REG_ADD_LAT: add_lat_ff <= csr_pwdata[5:0];
            tidb_pkg::REG_MUL_LAT: mul_lat_ff <= csr_pwdata[5:0];
            tidb_pkg::REG_DIV_LAT: div_lat_ff <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         tidb_pkg::REG_ADD_LAT: csr_prdata = {26'd0, add_lat_ff};
         tidb_pkg::REG_MUL_LAT: csr_prdata = {26'd0, mul_lat_ff};
         tidb_pkg::REG_DIV_LAT: csr_prdata = {26'd0, div_lat_ff};
         default:               csr_prdata = '0;
      endcase
   end

   // instruction queue memory, {op, dest, src1, src2}
   logic [10:0]     queue_mem [QUEUE_DEPTH];
   logic [10:0]     head_q;
   logic [QW-1:0]   head_ff;
   logic [CW-1:0]   occ_ff;
   logic [QW-1:0]   tail;

   // architectural state
   logic [DATA_WIDTH-1:0] regs_ff [NUM_REGS];
   logic                  ratp_ff [NUM_REGS];
   logic [TW-1:0]         ratt_ff [NUM_REGS];
   // stations: index 0..ADD-1 add class, rest mul class; tag = index+1
   logic                  busy_ff [NS];
   logic                  sop_ff  [NS];
   logic [RW-1:0]         sdst_ff [NS];
   logic [TW-1:0]         t1_ff   [NS];
   logic [TW-1:0]         t2_ff   [NS];
   logic [DATA_WIDTH-1:0] v1_ff   [NS];
   logic [DATA_WIDTH-1:0] v2_ff   [NS];
   // execution units
   logic                  abusy_ff, mbusy_ff;
   logic [AW-1:0]         aslot_ff;
   logic [MW-1:0]         mslot_ff;
   logic [5:0]            acnt_ff, mcnt_ff;

   state_type state_ff;
   logic        issued_ff, stall_ff, full_ff, bv_ff, dz_ff;
   logic [2:0]  btag_ff, breg_ff;
   logic [31:0] bval_ff;
   logic [SW-1:0] fin_ff;

   assign tail = QW'((CW'(head_ff) + occ_ff) % QUEUE_DEPTH);

   always_ff @(posedge clock) begin
      if (req.valid && req.ready && req.command == tidb_pkg::CMD_ENQUEUE
          && occ_ff < CW'(QUEUE_DEPTH))
         queue_mem[tail] <= {req.opcode, req.dest_reg, req.src1_reg, req.src2_reg};
      head_q <= queue_mem[head_ff];
   end

   // shared alu
   tidb_pkg::alu_req_type alu_req;
   tidb_pkg::alu_rsp_type alu_rsp;
   logic [DATA_WIDTH-1:0] alu_res;
   logic                  fin_md;
   logic [1:0]            fin_op;

   assign fin_op = {fin_md, sop_ff[fin_ff]};
   assign alu_req.start = (state_ff == S_BCAST) && (bv_ff);
   assign alu_req.op    = fin_op;

   tidb_alu #(.DATA_WIDTH(DATA_WIDTH)) u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .a      (v1_ff[fin_ff]),
      .b      (v2_ff[fin_ff]),
      .rsp    (alu_rsp),
      .result (alu_res)
   );

   // dispatch scan: first ready station of each class
   logic           a_rdy, m_rdy;
   logic [AW-1:0]  a_sel;
   logic [MW-1:0]  m_sel;
   always_comb begin
      a_rdy = 1'b0;
      a_sel = '0;
      for (int i = ADD_STATIONS - 1; i >= 0; i--)
         if (busy_ff[i] && t1_ff[i] == '0 && t2_ff[i] == '0) begin
            a_rdy = 1'b1;
            a_sel = AW'(i);
         end
      m_rdy = 1'b0;
      m_sel = '0;
      for (int i = MUL_STATIONS - 1; i >= 0; i--)
         if (busy_ff[ADD_STATIONS + i] && t1_ff[ADD_STATIONS + i] == '0
             && t2_ff[ADD_STATIONS + i] == '0) begin
            m_rdy = 1'b1;
            m_sel = MW'(i);
         end
   end

   // issue scan on the queue head
   logic          h_md;
   logic [RW-1:0] h_d, h_s1, h_s2;
   logic          free_ok;
   logic [SW-1:0] free_sel;
   assign h_md = head_q[10];
   assign h_d  = RW'(head_q[8:6] % NUM_REGS);
   assign h_s1 = RW'(head_q[5:3] % NUM_REGS);
   assign h_s2 = RW'(head_q[2:0] % NUM_REGS);
   always_comb begin
      free_ok  = 1'b0;
      free_sel = '0;
      if (h_md) begin
         for (int i = MUL_STATIONS - 1; i >= 0; i--)
            if (!busy_ff[ADD_STATIONS + i]) begin
               free_ok  = 1'b1;
               free_sel = SW'(ADD_STATIONS + i);
            end
      end else begin
         for (int i = ADD_STATIONS - 1; i >= 0; i--)
            if (!busy_ff[i]) begin
               free_ok  = 1'b1;
               free_sel = SW'(i);
            end
      end
   end

   logic [TW-1:0] fin_tag;
   logic [RW-1:0] fin_dst;
   assign fin_tag = TW'(fin_ff) + TW'(1);
   assign fin_dst = sdst_ff[fin_ff];

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.broadcast_valid = bv_ff;
   assign rsp.broadcast_tag   = btag_ff;
   assign rsp.broadcast_reg   = breg_ff;
   assign rsp.broadcast_value = bval_ff;
   assign rsp.divide_by_zero  = dz_ff;
   assign rsp.issued          = issued_ff;
   assign rsp.issue_stalled   = stall_ff;
   assign rsp.queue_full      = full_ff;
   assign rsp.queue_count     = 5'(occ_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         occ_ff   <= '0;
         abusy_ff <= 1'b0;
         mbusy_ff <= 1'b0;
         acnt_ff  <= '0;
         mcnt_ff  <= '0;
         aslot_ff <= '0;
         mslot_ff <= '0;
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
            ratp_ff[i] <= 1'b0;
            ratt_ff[i] <= '0;
         end
         for (int i = 0; i < NS; i++) begin
            busy_ff[i] <= 1'b0;
            sop_ff[i]  <= 1'b0;
            sdst_ff[i] <= '0;
            t1_ff[i]   <= '0;
            t2_ff[i]   <= '0;
            v1_ff[i]   <= '0;
            v2_ff[i]   <= '0;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  issued_ff <= 1'b0;
                  stall_ff  <= 1'b0;
                  full_ff   <= 1'b0;
                  bv_ff     <= 1'b0;
                  btag_ff   <= '0;
                  breg_ff   <= '0;
                  bval_ff   <= '0;
                  dz_ff     <= 1'b0;
                  fin_md    <= 1'b0;
                  unique case (req.command)
                     tidb_pkg::CMD_PRELOAD: begin
                        regs_ff[RW'(req.reg_index % NUM_REGS)] <=
                           DATA_WIDTH'($signed(req.reg_value));
                        ratp_ff[RW'(req.reg_index % NUM_REGS)] <= 1'b0;
                        ratt_ff[RW'(req.reg_index % NUM_REGS)] <= '0;
                        state_ff <= S_OUT;
                     end
                     tidb_pkg::CMD_ENQUEUE: begin
                        if (occ_ff >= CW'(QUEUE_DEPTH)) full_ff <= 1'b1;
                        else occ_ff <= occ_ff + 1'b1;
                        state_ff <= S_OUT;
                     end
                     tidb_pkg::CMD_TICK: begin
                        // countdowns
                        if (abusy_ff && acnt_ff != '0) acnt_ff <= acnt_ff - 1'b1;
                        if (mbusy_ff && mcnt_ff != '0) mcnt_ff <= mcnt_ff - 1'b1;
                        state_ff <= S_DISP;
                     end
                     default: state_ff <= S_OUT;
                  endcase
               end
            end
            S_DISP: begin
               if (!abusy_ff && a_rdy) begin
                  abusy_ff <= 1'b1;
                  aslot_ff <= a_sel;
                  acnt_ff  <= add_lat_ff;
               end
               if (!mbusy_ff && m_rdy) begin
                  mbusy_ff <= 1'b1;
                  mslot_ff <= m_sel;
                  mcnt_ff  <= sop_ff[ADD_STATIONS + int'(m_sel)] ? div_lat_ff : mul_lat_ff;
               end
               state_ff <= S_ISSUE;
            end
            S_ISSUE: begin
               if (occ_ff != '0) begin
                  if (free_ok) begin
                     issued_ff          <= 1'b1;
                     busy_ff[free_sel]  <= 1'b1;
                     sop_ff[free_sel]   <= head_q[9];
                     sdst_ff[free_sel]  <= h_d;
                     t1_ff[free_sel]    <= ratp_ff[h_s1] ? ratt_ff[h_s1] : '0;
                     v1_ff[free_sel]    <= ratp_ff[h_s1] ? '0 : regs_ff[h_s1];
                     t2_ff[free_sel]    <= ratp_ff[h_s2] ? ratt_ff[h_s2] : '0;
                     v2_ff[free_sel]    <= ratp_ff[h_s2] ? '0 : regs_ff[h_s2];
                     ratp_ff[h_d]       <= 1'b1;
                     ratt_ff[h_d]       <= TW'(free_sel) + TW'(1);
                     head_ff <= QW'((CW'(head_ff) + CW'(1)) % QUEUE_DEPTH);
                     occ_ff  <= occ_ff - 1'b1;
                  end else begin
                     stall_ff <= 1'b1;
                  end
               end
               // pick the finishing unit, mul/div first
               if (mbusy_ff && mcnt_ff == '0) begin
                  bv_ff  <= 1'b1;
                  fin_md <= 1'b1;
                  fin_ff <= SW'(ADD_STATIONS + int'(mslot_ff));
                  mbusy_ff <= 1'b0;
               end else if (abusy_ff && acnt_ff == '0) begin
                  bv_ff  <= 1'b1;
                  fin_md <= 1'b0;
                  fin_ff <= SW'(aslot_ff);
                  abusy_ff <= 1'b0;
               end
               state_ff <= S_BCAST;
            end
            S_BCAST: begin
               state_ff <= bv_ff ? S_WAIT : S_OUT;
            end
            S_WAIT: begin
               if (alu_rsp.done) state_ff <= S_FIN;
            end
            S_FIN: begin
               btag_ff <= 3'(fin_tag);
               breg_ff <= 3'(fin_dst);
               bval_ff <= 32'(alu_res);
               dz_ff   <= alu_rsp.dz && fin_md;
               busy_ff[fin_ff] <= 1'b0;
               sop_ff[fin_ff]  <= 1'b0;
               sdst_ff[fin_ff] <= '0;
               t1_ff[fin_ff]   <= '0;
               t2_ff[fin_ff]   <= '0;
               v1_ff[fin_ff]   <= '0;
               v2_ff[fin_ff]   <= '0;
               for (int i = 0; i < NS; i++) begin
                  if (busy_ff[i] && SW'(i) != fin_ff) begin
                     if (t1_ff[i] == fin_tag) begin
                        t1_ff[i] <= '0;
                        v1_ff[i] <= alu_res;
                     end
                     if (t2_ff[i] == fin_tag) begin
                        t2_ff[i] <= '0;
                        v2_ff[i] <= alu_res;
                     end
                  end
               end
               if (ratp_ff[fin_dst] && ratt_ff[fin_dst] == fin_tag) begin
                  ratp_ff[fin_dst] <= 1'b0;
                  ratt_ff[fin_dst] <= '0;
                  regs_ff[fin_dst] <= alu_res;
               end
               if (fin_md) mcnt_ff <= '0;
               else acnt_ff <= '0;
               state_ff <= S_OUT;
            end
            default: begin
               if (rsp.ready) state_ff <= S_IDLE;
            end
         endcase
      end
   end
endmodule

[test/tidb_core_checker.sv]
// checker: predicts each response word of the tomasulo unit and compares it
`timescale 1ns / 1ps
module tidb_core_checker (
   input  logic        clock,
   input  logic        reset,
   tidb_req_if         req,
   tidb_rsp_if         rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending
);
   import tidb_pkg::*;

   typedef struct packed {
      logic        bv;
      logic [2:0]  tag;
      logic [2:0]  dreg;
      logic [31:0] val;
      logic        dz;
      logic        iss;
      logic        stl;
      logic        qf;
      logic [4:0]  qc;
   } bus_word_type;

   bus_word_type expected_words[$];

   logic [5:0]  lat_add, lat_mul, lat_div;
   logic [10:0] iq[16];
   logic [4:0]  q_occ;
   logic [3:0]  q_head;
   logic [31:0] rf[8];
   logic        rat_p[8];
   logic [2:0]  rat_t[8];
   // stations 0..2 add/sub, 3..4 mul/div; tag is index + 1
   logic        st_busy[5];
   logic        st_op[5];
   logic [2:0]  st_dest[5], st_t1[5], st_t2[5];
   logic [31:0] st_v1[5], st_v2[5];
   logic        au_busy, mu_busy;
   int          au_slot, mu_slot;
   logic [5:0]  au_cnt, mu_cnt;

   task automatic clear_core();
      lat_add = ADD_LAT_RESET; lat_mul = MUL_LAT_RESET; lat_div = DIV_LAT_RESET;
      q_occ = 0; q_head = 0;
      for (int i = 0; i < 8; i++) begin
         rf[i] = 0; rat_p[i] = 0; rat_t[i] = 0;
      end
      for (int i = 0; i < 5; i++) begin
         st_busy[i] = 0; st_op[i] = 0; st_dest[i] = 0; st_t1[i] = 0; st_t2[i] = 0;
         st_v1[i] = 0; st_v2[i] = 0;
      end
      au_busy = 0; mu_busy = 0; au_slot = 0; mu_slot = 0; au_cnt = 0; mu_cnt = 0;
   endtask

   // finish the station in slot s and put its result on the bus
   task automatic retire(input int s, input bit md, inout bus_word_type w);
      logic [31:0] a, b, r;
      logic        dz;
      longint      qa;
      logic [2:0]  tag, d;
      a = st_v1[s]; b = st_v2[s]; dz = 0;
      if (!md) r = st_op[s] ? a - b : a + b;
      else if (st_op[s]) begin
         if (b == 0) begin
            dz = 1; r = 0;
         end else begin
            qa = longint'($signed(a)) / longint'($signed(b));
            r = qa[31:0];
         end
      end else r = a * b;
      tag = 3'(s + 1);
      d = st_dest[s];
      st_busy[s] = 0; st_op[s] = 0; st_dest[s] = 0; st_t1[s] = 0; st_t2[s] = 0;
      st_v1[s] = 0; st_v2[s] = 0;
      for (int i = 0; i < 5; i++) begin
         if (st_busy[i]) begin
            if (st_t1[i] == tag) begin st_t1[i] = 0; st_v1[i] = r; end
            if (st_t2[i] == tag) begin st_t2[i] = 0; st_v2[i] = r; end
         end
      end
      // only the latest producer of the register writes it
      if (rat_p[d] && rat_t[d] == tag) begin
         rat_p[d] = 0; rat_t[d] = 0; rf[d] = r;
      end
      w.bv = 1; w.tag = tag; w.dreg = d; w.val = r; w.dz = dz;
   endtask

   task automatic model_core_step(output bus_word_type w);
      logic [10:0] e;
      logic [1:0]  op;
      logic [2:0]  d, s1, s2;
      int          lo, hi, got;
      w = '0;
      case (cmd_type'(req.command))
         CMD_PRELOAD: begin
            rf[req.reg_index] = req.reg_value;
            rat_p[req.reg_index] = 0;
            rat_t[req.reg_index] = 0;
         end
         CMD_ENQUEUE: begin
            if (q_occ >= 16) w.qf = 1;
            else begin
               iq[4'(q_head + q_occ)] = {req.opcode, req.dest_reg, req.src1_reg,
                                         req.src2_reg};
               q_occ++;
            end
         end
         CMD_TICK: begin
            if (au_busy && au_cnt > 0) au_cnt--;
            if (mu_busy && mu_cnt > 0) mu_cnt--;
            // dispatch: lowest ready station of each class
            if (!au_busy) begin
               for (int i = 0; i < 3; i++) begin
                  if (!au_busy && st_busy[i] && st_t1[i] == 0 && st_t2[i] == 0) begin
                     au_busy = 1; au_slot = i; au_cnt = lat_add;
                  end
               end
            end
            if (!mu_busy) begin
               for (int i = 3; i < 5; i++) begin
                  if (!mu_busy && st_busy[i] && st_t1[i] == 0 && st_t2[i] == 0) begin
                     mu_busy = 1; mu_slot = i; mu_cnt = st_op[i] ? lat_div : lat_mul;
                  end
               end
            end
            // issue the queue head in order
            if (q_occ != 0) begin
               e = iq[q_head];
               op = e[10:9]; d = e[8:6]; s1 = e[5:3]; s2 = e[2:0];
               lo = (op >= OP_MUL) ? 3 : 0;
               hi = (op >= OP_MUL) ? 5 : 3;
               got = 0;
               for (int i = lo; i < hi; i++) begin
                  if (!got && !st_busy[i]) begin
                     got = 1;
                     st_busy[i] = 1; st_op[i] = op[0]; st_dest[i] = d;
                     if (rat_p[s1]) begin st_t1[i] = rat_t[s1]; st_v1[i] = 0; end
                     else begin st_t1[i] = 0; st_v1[i] = rf[s1]; end
                     if (rat_p[s2]) begin st_t2[i] = rat_t[s2]; st_v2[i] = 0; end
                     else begin st_t2[i] = 0; st_v2[i] = rf[s2]; end
                     rat_p[d] = 1; rat_t[d] = 3'(i + 1);
                     q_head++;
                     q_occ--;
                  end
               end
               if (got) w.iss = 1;
               else w.stl = 1;
            end
            // one broadcast per tick, mul/div first
            if (mu_busy && mu_cnt == 0) begin
               retire(mu_slot, 1, w);
               mu_busy = 0;
            end else if (au_busy && au_cnt == 0) begin
               retire(au_slot, 0, w);
               au_busy = 0;
            end
         end
         default: ;
      endcase
      w.qc = q_occ;
   endtask

   always @(posedge clock) begin
      bus_word_type w, want;
      if (reset) begin
         clear_core();
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_ADD_LAT: lat_add = csr_pwdata[5:0];
               REG_MUL_LAT: lat_mul = csr_pwdata[5:0];
               REG_DIV_LAT: lat_div = csr_pwdata[5:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            model_core_step(w);
            expected_words.push_back(w);
         end
         if (rsp.valid && rsp.ready) begin
            w = {rsp.broadcast_valid, rsp.broadcast_tag, rsp.broadcast_reg,
                 rsp.broadcast_value, rsp.divide_by_zero, rsp.issued,
                 rsp.issue_stalled, rsp.queue_full, rsp.queue_count};
            if (expected_words.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response word %h at %0t", w, $realtime);
            end else begin
               want = expected_words.pop_front();
               if (w !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch at %0t: exp bv=%b tag=%0d reg=%0d val=%h",
                               " dz=%b iss=%b stl=%b qf=%b qc=%0d / got bv=%b",
                               " tag=%0d reg=%0d val=%h dz=%b iss=%b stl=%b qf=%b",
                               " qc=%0d"},
                        $realtime, want.bv, want.tag, want.dreg, want.val, want.dz,
                        want.iss, want.stl, want.qf, want.qc, w.bv, w.tag, w.dreg,
                        w.val, w.dz, w.iss, w.stl, w.qf, w.qc);
               end
            end
         end
      end
      pending = expected_words.size();
   end

endmodule

[test/tomasulo_issue_dispatch_broadcast_unit_tb.sv]
// testbench top: clock, reset, stimulus and verdict for the tomasulo unit
`timescale 1ns / 1ps
module tomasulo_issue_dispatch_broadcast_unit_tb;
   import tidb_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;

   tidb_req_if req ();
   tidb_rsp_if rsp ();

   tomasulo_issue_dispatch_broadcast_unit u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   tidb_core_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the unit hangs
   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   // idle length: mostly none, some short, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side stalls at random, with long stretches of ready too
   initial begin
      int n;
      rsp.ready <= 0;
      @(posedge clock);
      forever begin
         rsp.ready <= 1;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
         repeat (n) @(posedge clock);
         rsp.ready <= 0;
         n = gap_len() + 1;
         repeat (n) @(posedge clock);
      end
   end

   // offers one word and returns at the edge where it is taken
   task automatic send_word(input cmd_type c, input logic [2:0] ri, input logic [31:0] rv,
                            input op_type op, input logic [2:0] d, input logic [2:0] s1,
                            input logic [2:0] s2);
      int g;
      g = gap_len();
      if (g > 0) begin
         req.valid <= 0;
         repeat (g) @(posedge clock);
      end
      req.command <= c; req.reg_index <= ri; req.reg_value <= rv;
      req.opcode <= op; req.dest_reg <= d; req.src1_reg <= s1; req.src2_reg <= s2;
      req.valid <= 1;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic do_preload(input logic [2:0] r, input logic [31:0] v);
      send_word(CMD_PRELOAD, r, v, op_type'($urandom_range(0, 3)), 3'($urandom),
                3'($urandom), 3'($urandom));
   endtask

   task automatic do_enqueue(input op_type op, input logic [2:0] d, input logic [2:0] s1,
                             input logic [2:0] s2);
      send_word(CMD_ENQUEUE, 3'($urandom), $urandom, op, d, s1, s2);
   endtask

   task automatic do_tick();
      send_word(CMD_TICK, 3'($urandom), $urandom, op_type'($urandom_range(0, 3)),
                3'($urandom), 3'($urandom), 3'($urandom));
   endtask

   // drop valid and hold off until every response word has been taken
   task automatic wait_idle();
      req.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // apb write: setup cycle then access cycle
   task automatic csr_write(input logic [1:0] idx, input logic [5:0] v);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= {$urandom} & 32'hFFFF_FFC0 | v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic set_latencies(input logic [5:0] a, input logic [5:0] m, input logic [5:0] dv);
      csr_write(REG_ADD_LAT, a);
      csr_write(REG_MUL_LAT, m);
      csr_write(REG_DIV_LAT, dv);
   endtask

   initial begin
      int r, n;
      logic [31:0] v;
      reset <= 1;
      req.valid <= 0; req.command <= CMD_NONE; req.reg_index <= 0; req.reg_value <= 0;
      req.opcode <= OP_ADD; req.dest_reg <= 0; req.src1_reg <= 0; req.src2_reg <= 0;
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0; csr_paddr <= 0; csr_pwdata <= 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero add latency, operand extremes, overflow and divide corners
      set_latencies(6'd0, 6'd1, 6'd3);
      do_preload(3'd0, 32'h7FFF_FFFF);
      do_preload(3'd1, 32'h8000_0000);
      do_preload(3'd2, 32'hFFFF_FFFF);
      do_preload(3'd3, 32'h0);
      do_preload(3'd4, 32'd5);
      do_enqueue(OP_ADD, 3'd5, 3'd0, 3'd4);   // add wraps
      do_enqueue(OP_SUB, 3'd6, 3'd1, 3'd4);   // sub wraps
      do_enqueue(OP_MUL, 3'd7, 3'd0, 3'd0);   // mul wraps
      do_enqueue(OP_DIV, 3'd5, 3'd1, 3'd3);   // divide by zero
      do_enqueue(OP_DIV, 3'd6, 3'd1, 3'd2);   // most negative over minus one
      do_enqueue(OP_ADD, 3'd0, 3'd5, 3'd5);   // waits on a tag
      send_word(CMD_NONE, 3'd7, 32'hFFFF_FFFF, OP_DIV, 3'd7, 3'd7, 3'd7);
      repeat (12) do_tick();
      wait_idle();

      // random phases over several latency settings
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: set_latencies(6'd1, 6'd1, 6'd1);
            1: set_latencies(6'd63, 6'd63, 6'd63);
            2: set_latencies(6'($urandom), 6'($urandom), 6'($urandom));
            3: set_latencies(ADD_LAT_RESET, MUL_LAT_RESET, DIV_LAT_RESET);
            default: set_latencies(6'd0, 6'd0, 6'd0);
         endcase
         n = 0;
         while (n < 200) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               case ($urandom_range(0, 9))
                  0: v = 32'h7FFF_FFFF;
                  1: v = 32'h8000_0000;
                  2: v = 32'hFFFF_FFFF;
                  3: v = 32'h0;
                  default: v = $urandom;
               endcase
               do_preload(3'($urandom), v);
               n++;
            end else if (r < 38) begin
               do_enqueue(op_type'($urandom_range(0, 3)), 3'($urandom), 3'($urandom),
                          3'($urandom));
               n++;
            end else if (r < 40) begin
               // burst that overruns the queue
               repeat (18) do_enqueue(op_type'($urandom_range(0, 3)), 3'($urandom),
                                      3'($urandom), 3'($urandom));
               n += 18;
            end else if (r < 43) begin
               send_word(CMD_NONE, 3'($urandom), $urandom, op_type'($urandom_range(0, 3)),
                         3'($urandom), 3'($urandom), 3'($urandom));
               n++;
            end else begin
               do_tick();
               n++;
            end
         end
         // sender holds off until all words are back
         wait_idle();
      end

      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
